/* rtl/core/tlb_pkg.sv */
package tlb_pkg;

  localparam logic [1:0] KIND_RD = 2'd0;
  localparam logic [1:0] KIND_WR = 2'd1;
  localparam logic [1:0] KIND_FL = 2'd2;

  localparam int ADDR_W      = 24;
  localparam int LIM_W       = 25;
  localparam int RESET_PAGES = 16;
  localparam logic [16:0] RESET_LIMIT = 17'h10000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        size_code;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       wdata;
    logic              hit;
    logic              in_range;
    logic [63:0]       hits;
    logic [63:0]       misses;
  } op_t;

endpackage

/* rtl/core/tlb_ram.sv */
module tlb_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tlb_queue.sv */
module tlb_queue import tlb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head,
  output logic full,
  output logic empty
);

  op_t        ent_r [2];
  logic [1:0] count_r;
  logic       wp_r;
  logic       rp_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_op;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of bounds");
`endif

endmodule

/* rtl/core/tlb_front.sv */
module tlb_front import tlb_pkg::*; #(
  parameter int PAGE_BITS   = 12,
  parameter int TLB_ENTRIES = 64,
  parameter int RAM_BYTES   = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [1:0]  in_size_code,
  input  logic [63:0] in_address,
  input  logic [63:0] in_write_data,
  input  logic [16:0] ram_limit,
  input  logic        blocked,
  input  logic        q_full,
  output logic        push,
  output op_t         push_op
);

  localparam int SB    = $clog2(TLB_ENTRIES);
  localparam int TAG_W = 64 - PAGE_BITS;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic                   state_r;
  logic [1:0]             kind_r;
  logic [1:0]             size_r;
  logic [63:0]            addr_r;
  logic [63:0]            wdata_r;
  logic [TLB_ENTRIES-1:0] valid_r;
  logic [TLB_ENTRIES-1:0] wr_r;
  logic [63:0]            hits_r;
  logic [63:0]            misses_r;

  logic [TAG_W-1:0] vpn;
  logic [SB-1:0]    slot;
  logic [SB-1:0]    in_slot;
  logic [SB-1:0]    tag_raddr;
  logic [TAG_W-1:0] tag_q;
  logic [TAG_W-1:0] rtag;
  logic             hit;
  logic             is_acc;
  logic             go;
  logic             tag_we;
  logic [3:0]       nm1;
  logic [LIM_W-1:0] last;
  logic [LIM_W-1:0] lim;
  logic [LIM_W-1:0] eff;
  logic             inr;

  assign in_ready  = (state_r == ST_IDLE) && !blocked && !q_full;
  assign in_slot   = in_address[PAGE_BITS +: SB];
  assign vpn       = addr_r[63:PAGE_BITS];
  assign slot      = vpn[SB-1:0];
  assign tag_raddr = (state_r == ST_IDLE) ? in_slot : slot;
  assign rtag      = wr_r[slot] ? tag_q : TAG_W'(slot);
  assign is_acc    = (kind_r == KIND_RD) || (kind_r == KIND_WR);
  assign hit       = is_acc && valid_r[slot] && (rtag == vpn);
  assign go        = (state_r == ST_LOOK) && !q_full;
  assign tag_we    = go && is_acc && !hit;
  assign nm1       = (4'd1 << size_r) - 4'd1;
  assign last      = {1'b0, addr_r[ADDR_W-1:0]} + LIM_W'(nm1);
  assign lim       = LIM_W'(ram_limit);
  assign eff       = (lim > LIM_W'(RAM_BYTES)) ? LIM_W'(RAM_BYTES) : lim;
  assign inr       = is_acc && (addr_r[63:ADDR_W] == '0) && (last < eff);
  assign push      = go;

  always_comb begin
    push_op           = '0;
    push_op.kind      = kind_r;
    push_op.size_code = size_r;
    push_op.addr      = addr_r[ADDR_W-1:0];
    push_op.wdata     = wdata_r;
    push_op.hit       = hit;
    push_op.in_range  = inr;
    push_op.hits      = (is_acc && hit) ? hits_r + 64'd1 : hits_r;
    push_op.misses    = (is_acc && !hit) ? misses_r + 64'd1 : misses_r;
  end

  tlb_ram #(.W(TAG_W), .D(TLB_ENTRIES)) u_tag (
    .clk   (clk),
    .we    (tag_we),
    .waddr (slot),
    .wdata (vpn),
    .raddr (tag_raddr),
    .rdata (tag_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= {{(TLB_ENTRIES-RESET_PAGES){1'b0}}, {RESET_PAGES{1'b1}}};
      wr_r     <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else begin
      if (in_valid && in_ready) begin
        state_r <= ST_LOOK;
      end else if (go) begin
        state_r <= ST_IDLE;
      end
      if (go) begin
        hits_r   <= push_op.hits;
        misses_r <= push_op.misses;
        if (kind_r == KIND_FL) begin
          valid_r <= '0;
        end else if (tag_we) begin
          valid_r[slot] <= 1'b1;
          wr_r[slot]    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= in_kind;
      size_r  <= in_size_code;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
    end
  end

`ifndef SYNTHESIS
  a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> ($countones({hits_r != $past(hits_r), misses_r != $past(misses_r)})
            == ($past(is_acc) ? 1 : 0))) else $error("counter update mismatch");
  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> state_r == ST_IDLE) else $error("front not idle after push");
  a_miss_fill: assert property (@(posedge clk) disable iff (!rst_n)
    tag_we |=> valid_r[$past(slot)]) else $error("miss did not fill entry");
`endif

endmodule

/* rtl/core/tlb_back.sv */
module tlb_back import tlb_pkg::*; #(
  parameter int RAM_BYTES = 65536
) (
  input  logic         clk,
  input  logic         rst_n,
  input  op_t          head,
  input  logic         empty,
  output logic         pop,
  output logic         clearing,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [199:0] out_data
);

  localparam int AW   = $clog2(RAM_BYTES);
  localparam int ROWS = RAM_BYTES / 8;
  localparam int RW   = $clog2(ROWS);

  logic          clr_busy_r;
  logic [RW-1:0] clr_row_r;
  logic          s2_v_r;
  op_t           s2_op_r;
  logic          out_v_r;
  logic [199:0]  out_r;

  logic [AW-1:0] a;
  logic [2:0]    off;
  logic [RW-1:0] row0;
  logic [3:0]    n4;
  logic [2:0]    nm1;
  logic [2:0]    s2_off;
  logic [3:0]    s2_n4;
  logic [2:0]    s2_nm1;
  logic [63:0]   rd;

  logic [RW-1:0] b_row [8];
  logic [RW-1:0] b_waddr [8];
  logic          b_we [8];
  logic [7:0]    b_wd [8];
  logic [7:0]    bank_q [8];

  assign clearing  = clr_busy_r;
  assign pop       = !clr_busy_r && !empty && !s2_v_r && (!out_v_r || out_ready);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign a    = head.addr[AW-1:0];
  assign off  = a[2:0];
  assign row0 = a[AW-1:3];
  assign n4   = 4'd1 << head.size_code;
  assign nm1  = 3'(n4 - 4'd1);

  always_comb begin
    logic [2:0] idx;
    logic [2:0] d;
    for (int b = 0; b < 8; b++) begin
      idx      = 3'(b) - off;
      d        = nm1 - idx;
      b_row[b] = row0 + RW'(3'(b) < off);
      b_we[b]  = clr_busy_r || (pop && head.kind == KIND_WR && head.in_range
                                && ({1'b0, idx} < n4));
      b_wd[b]  = clr_busy_r ? 8'd0 : 8'(head.wdata >> {d, 3'b000});
      b_waddr[b] = clr_busy_r ? clr_row_r : b_row[b];
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_bank
    tlb_ram #(.W(8), .D(ROWS)) u_bank (
      .clk   (clk),
      .we    (b_we[g]),
      .waddr (b_waddr[g]),
      .wdata (b_wd[g]),
      .raddr (b_row[g]),
      .rdata (bank_q[g])
    );
  end

  assign s2_off = s2_op_r.addr[2:0];
  assign s2_n4  = 4'd1 << s2_op_r.size_code;
  assign s2_nm1 = 3'(s2_n4 - 4'd1);

  always_comb begin
    rd = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < s2_n4) begin
        rd = rd | (64'(bank_q[3'(s2_off + 3'(i))]) << {3'(s2_nm1 - 3'(i)), 3'b000});
      end
    end
    if (!(s2_op_r.kind == KIND_RD && s2_op_r.in_range)) begin
      rd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_row_r <= clr_row_r + RW'(1);
        if (clr_row_r == RW'(ROWS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      s2_v_r <= pop;
      if (s2_v_r) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_op_r <= head;
    end
    if (s2_v_r) begin
      out_r <= {6'd0, s2_op_r.misses, s2_op_r.hits, s2_op_r.in_range, s2_op_r.hit, rd};
    end
  end

`ifndef SYNTHESIS
  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !out_v_r && !s2_v_r) else $error("result during clearing");
  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |=> out_v_r && !s2_v_r) else $error("stage two not delivered");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> !out_v_r) else $error("output overwritten");
`endif

endmodule

/* rtl/core/tlb_translated_big_endian_memory_top.sv */
// Data TLB in front of a big-endian byte RAM.
// Input words carry a read, a write or a TLB flush; each accepted word yields
// exactly one output word with the read data, hit and range flags and both
// running TLB counters.
// The front end looks the page up in a direct-mapped tag RAM, fills an
// identity entry on a miss, checks the range and queues the word. The back
// end splits the access over eight byte-wide RAM banks and builds the
// big-endian result.
// The front end takes no new word until the last has left its lookup state,
// held by the tag RAM read and the tag update that follows it. An accepted
// word passes the queue, stage two and the output register to out_tvalid.
// The output register decouples the sides; while out_tready is low the word
// holds, the two-entry queue fills and then in_tready drops.
// After reset the RAM is cleared one row of eight bytes per cycle, over all
// RAM_BYTES / 8 rows; in_tready stays low meanwhile. Writes to ram_limit
// through cfg_we are taken at any time but belong in idle periods.
module tlb_translated_big_endian_memory_top import tlb_pkg::*; #(
  parameter int PAGE_BITS   = 12,
  parameter int TLB_ENTRIES = 64,
  parameter int RAM_BYTES   = 65536
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // kind, size_code, address, write_data, zero fill.
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // read_data, tlb_hit, in_range, hits_total, misses_total, zero fill.
  output logic [199:0] out_tdata,
  input  logic         cfg_we,
  input  logic [16:0]  cfg_wdata
);

  logic [16:0] ram_limit_r;
  logic        clearing;
  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  op_t         push_op;
  op_t         head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_limit_r <= RESET_LIMIT;
    end else if (cfg_we) begin
      ram_limit_r <= cfg_wdata;
    end
  end

  tlb_front #(
    .PAGE_BITS   (PAGE_BITS),
    .TLB_ENTRIES (TLB_ENTRIES),
    .RAM_BYTES   (RAM_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_kind       (in_tdata[1:0]),
    .in_size_code  (in_tdata[3:2]),
    .in_address    (in_tdata[67:4]),
    .in_write_data (in_tdata[131:68]),
    .ram_limit     (ram_limit_r),
    .blocked       (clearing),
    .q_full        (q_full),
    .push          (push),
    .push_op       (push_op)
  );

  tlb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  tlb_back #(.RAM_BYTES(RAM_BYTES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

/* sim/tlb_translated_big_endian_memory_top_tb.sv */
`timescale 1ns / 1ps

module tlb_translated_big_endian_memory_top_tb;
  import tlb_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [63:0] read_data;
    logic        tlb_hit;
    logic        in_range;
    logic [63:0] hits;
    logic [63:0] misses;
  } access_result_t;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  size_code;
    logic [63:0] addr;
    logic [63:0] wdata;
    bit          typed;
    logic [63:0] read_data;
    logic        tlb_hit;
    logic        in_range;
  } access_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [199:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [16:0]  cfg_wdata = '0;

  logic [7:0]  mem_bytes [0:65535];
  logic [51:0] page_tag [0:63];
  logic        page_valid [0:63];
  logic [63:0] hit_count;
  logic [63:0] miss_count;
  logic [16:0] limit_reg;

  access_result_t expected_words [$];
  access_row_t    directed_rows [$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  steady = 1'b0;

  tlb_translated_big_endian_memory_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic access_result_t translate_access(logic [1:0] kind, logic [1:0] size_code,
                                                      logic [63:0] addr, logic [63:0] wdata);
    access_result_t r;
    logic [51:0] vpn;
    logic [5:0]  slot;
    logic [64:0] last;
    logic [63:0] eff;
    int          nbytes;
    r.read_data = '0;
    r.tlb_hit = 1'b0;
    r.in_range = 1'b0;
    nbytes = 1 << size_code;
    if (kind == KIND_FL) begin
      for (int i = 0; i < 64; i++) page_valid[i] = 1'b0;
    end else if (kind == KIND_RD || kind == KIND_WR) begin
      vpn = addr[63:12];
      slot = vpn[5:0];
      if (page_valid[slot] && page_tag[slot] == vpn) begin
        r.tlb_hit = 1'b1;
        hit_count++;
      end else begin
        miss_count++;
        page_tag[slot] = vpn;
        page_valid[slot] = 1'b1;
      end
      last = {1'b0, addr} + 65'(nbytes - 1);
      eff = (limit_reg > 17'h10000) ? 64'h10000 : 64'(limit_reg);
      if (!last[64] && last[63:0] < eff) begin
        r.in_range = 1'b1;
        for (int i = 0; i < nbytes; i++) begin
          if (kind == KIND_RD)
            r.read_data = (r.read_data << 8) | 64'(mem_bytes[16'(addr + 64'(i))]);
          else
            mem_bytes[16'(addr + 64'(i))] = 8'(wdata >> (8 * (nbytes - 1 - i)));
        end
      end
    end
    r.hits = hit_count;
    r.misses = miss_count;
    return r;
  endfunction

  task automatic send_word(access_row_t row);
    access_result_t r;
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, row.wdata, row.addr, row.size_code, row.kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = translate_access(row.kind, row.size_code, row.addr, row.wdata);
    if (row.typed) begin
      r.read_data = row.read_data;
      r.tlb_hit = row.tlb_hit;
      r.in_range = row.in_range;
    end
    expected_words.push_back(r);
    if (!steady && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_limit(logic [16:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = value;
  endtask

  function automatic access_row_t row_of(logic [1:0] kind, logic [1:0] size_code,
                                         logic [63:0] addr, logic [63:0] wdata, bit typed,
                                         logic [63:0] rd, logic hit, logic inr);
    access_row_t row;
    row.kind = kind;
    row.size_code = size_code;
    row.addr = addr;
    row.wdata = wdata;
    row.typed = typed;
    row.read_data = rd;
    row.tlb_hit = hit;
    row.in_range = inr;
    return row;
  endfunction

  function automatic access_row_t random_row();
    access_row_t row;
    int          pick;
    row.typed = 1'b0;
    pick = $urandom_range(99);
    row.kind = (pick < 4) ? KIND_FL : (pick < 6) ? KIND_UNUSED :
               (pick < 53) ? KIND_RD : KIND_WR;
    row.size_code = 2'($urandom_range(3));
    row.wdata = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 60)
      row.addr = 64'($urandom_range(20'h1FFFF));
    else if (pick < 75)
      row.addr = {20'($urandom), 32'($urandom_range(63)), 12'($urandom)};
    else if (pick < 85)
      row.addr = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(15));
    else if (pick < 95)
      row.addr = 64'(limit_reg) - 64'($urandom_range(8)) + 64'($urandom_range(2));
    else
      row.addr = {$urandom, $urandom};
    return row;
  endfunction

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 13);
  end

  always @(posedge clk) begin
    access_result_t e;
    logic [63:0] rd, hits, misses;
    logic hit, inr;
    if (rst_n && out_tvalid && out_tready) begin
      rd = out_tdata[63:0];
      hit = out_tdata[64];
      inr = out_tdata[65];
      hits = out_tdata[129:66];
      misses = out_tdata[193:130];
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output word %h", out_tdata);
      end else begin
        e = expected_words.pop_front();
        if (rd !== e.read_data || hit !== e.tlb_hit || inr !== e.in_range ||
            hits !== e.hits || misses !== e.misses) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected data %h hit %b range %b hits %0d misses %0d, got data %h hit %b range %b hits %0d misses %0d",
                     e.read_data, e.tlb_hit, e.in_range, e.hits, e.misses,
                     rd, hit, inr, hits, misses);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tlb_translated_big_endian_memory_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [16:0] limits [6];
    for (int i = 0; i < 65536; i++) mem_bytes[i] = 8'h00;
    for (int i = 0; i < 64; i++) begin
      page_tag[i] = 52'(i);
      page_valid[i] = (i < RESET_PAGES);
    end
    hit_count = '0;
    miss_count = '0;
    limit_reg = RESET_LIMIT;

    directed_rows.push_back(row_of(KIND_RD, 2'd3, 64'h0, 64'h0, 1, 64'h0, 1'b1, 1'b1));
    directed_rows.push_back(row_of(KIND_WR, 2'd3, 64'h0, 64'h0102_0304_0506_0708, 0, 0, 0, 0));
    directed_rows.push_back(row_of(KIND_RD, 2'd0, 64'h0, 64'h0, 0, 0, 0, 0));
    directed_rows.push_back(row_of(KIND_RD, 2'd3, 64'h0, 64'h0, 0, 0, 0, 0));
    directed_rows.push_back(row_of(KIND_RD, 2'd2, 64'h2, 64'h0, 0, 0, 0, 0));
    directed_rows.push_back(row_of(KIND_WR, 2'd0, 64'hFFFF, 64'hFFFF_FFFF_FFFF_FFA5, 0, 0, 0, 0));
    directed_rows.push_back(row_of(KIND_RD, 2'd1, 64'hFFFF, 64'h0, 1, 64'h0, 1'b1, 1'b0));
    directed_rows.push_back(row_of(KIND_RD, 2'd3, 64'hFFF8, 64'h0, 0, 0, 0, 0));
    directed_rows.push_back(row_of(KIND_RD, 2'd3, 64'hFFFF_FFFF_FFFF_FFFC, 64'h0,
                                   1, 64'h0, 1'b0, 1'b0));
    directed_rows.push_back(row_of(KIND_WR, 2'd2, 64'hFFFF_FFFF_FFFF_FFFF,
                                   64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0));
    directed_rows.push_back(row_of(KIND_RD, 2'd2, 64'h10000, 64'h0, 1, 64'h0, 1'b0, 1'b0));
    directed_rows.push_back(row_of(KIND_RD, 2'd2, 64'h10000, 64'h0, 1, 64'h0, 1'b1, 1'b0));
    directed_rows.push_back(row_of(KIND_FL, 2'd0, 64'h0, 64'h0, 1, 64'h0, 1'b0, 1'b0));
    directed_rows.push_back(row_of(KIND_RD, 2'd0, 64'h0, 64'h0, 0, 0, 0, 0));
    directed_rows.push_back(row_of(KIND_UNUSED, 2'd3, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                                   1, 64'h0, 1'b0, 1'b0));
    directed_rows.push_back(row_of(KIND_WR, 2'd3, 64'h1000, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0));
    directed_rows.push_back(row_of(KIND_RD, 2'd1, 64'h1006, 64'h0, 0, 0, 0, 0));
    directed_rows.push_back(row_of(KIND_RD, 2'd3, 64'h41000, 64'h0, 0, 0, 0, 0));
    directed_rows.push_back(row_of(KIND_RD, 2'd3, 64'h1000, 64'h0, 0, 0, 0, 0));
    directed_rows.push_back(row_of(KIND_RD, 2'd0, 64'hAAAA_5555_AAAA_5555, 64'h0, 0, 0, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_word(directed_rows[i]);

    limits[0] = 17'h00000;
    limits[1] = 17'h1FFFF;
    limits[2] = 17'h00001;
    limits[3] = 17'd100000;
    limits[4] = 17'h01000 + 17'($urandom_range(4096));
    limits[5] = RESET_LIMIT;
    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      for (int n = 0; n < 222; n++) begin
        steady = (p == 3 && n >= 40 && n < 180);
        send_word(random_row());
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("tlb_translated_big_endian_memory_top_tb: PASS");
    else
      $display("tlb_translated_big_endian_memory_top_tb: FAIL");
    $finish;
  end

endmodule
